@@ sv/pwts_pkg.sv @@
// Shared constants, codes and types for the perspective world-to-screen block.
// Used by every module of the block; depends on nothing.
package pwts_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int COEF_SLOTS = 12;
	localparam int IDX_W      = 4;
	// Quotient bits below the saturation limit: one per divider stage.
	localparam int DIV_STAGES = WORD_W - 1;
	// Divider register count: its stages plus the signed result register.
	localparam int DIV_LAT    = DIV_STAGES + 1;
	localparam int DIM_W      = 15;
	localparam int DEPTH_W    = 17;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 64;

	// Item kinds carried on the input tuser.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	// Control that travels beside each point through the pipeline.
	typedef struct packed {
		logic valid;
		logic visible;
	} stage_ctl_t;

endpackage

@@ sv/pwts_dot.sv @@
// One matrix row times the homogeneous point, over two register stages.
// Depends on pwts_pkg.
module pwts_dot import pwts_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t c0,
	input  word_t c1,
	input  word_t c2,
	input  word_t c3,
	input  word_t x,
	input  word_t y,
	input  word_t z,
	output word_t dot_s3
);

	localparam int PROD_W = 2 * WORD_W - FRAC_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] SUM_MAX =
		SUM_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
	localparam logic signed [SUM_W-1:0] SUM_MIN =
		SUM_W'($signed({1'b1, {(WORD_W-1){1'b0}}}));

	logic signed [2*WORD_W-1:0] full0, full1, full2;
	logic signed [PROD_W-1:0]   p0_s2, p1_s2, p2_s2;
	word_t                      c3_s2;
	logic signed [SUM_W-1:0]    sum;
	word_t                      sat;

	// Exact products, floored to the fixed-point fraction by dropping low bits.
	assign full0 = c0 * x;
	assign full1 = c1 * y;
	assign full2 = c2 * z;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= full0[2*WORD_W-1:FRAC_BITS];
			p1_s2 <= full1[2*WORD_W-1:FRAC_BITS];
			p2_s2 <= full2[2*WORD_W-1:FRAC_BITS];
			c3_s2 <= c3;
		end
	end

	// Exact sum, then saturation to a signed word.
	always_comb begin
		sum = SUM_W'(p0_s2) + SUM_W'(p1_s2) + SUM_W'(p2_s2) + SUM_W'(c3_s2);
		if (sum > SUM_MAX)
			sat = {1'b0, {(WORD_W-1){1'b1}}};
		else if (sum < SUM_MIN)
			sat = {1'b1, {(WORD_W-1){1'b0}}};
		else
			sat = sum[WORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= sat;
		end
	end

endmodule

@@ sv/pwts_div.sv @@
// Pipelined restoring divider: fixed-point quotient, truncated toward zero, saturated.
// One quotient bit per stage, then a signed result register. Depends on pwts_pkg.
module pwts_div import pwts_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [WORD_W-1:0] mag,
	input  logic [WORD_W-2:0] den,
	input  logic              neg,
	output word_t             quo
);

	logic [WORD_W-2:0] rem_s  [0:DIV_STAGES];
	logic [WORD_W-2:0] bits_s [0:DIV_STAGES];
	logic [WORD_W-2:0] q_s    [0:DIV_STAGES];
	logic [WORD_W-2:0] den_s  [0:DIV_STAGES];
	logic              neg_s  [0:DIV_STAGES];
	logic              sat_s  [0:DIV_STAGES];
	logic [WORD_W-2:0] q_mag;

	// The integer part overflows exactly when mag / 2^(W-1-F) reaches den.
	assign rem_s[0]  = (WORD_W-1)'(mag[WORD_W-1:WORD_W-1-FRAC_BITS]);
	assign bits_s[0] = {mag[WORD_W-2-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
	assign q_s[0]    = '0;
	assign den_s[0]  = den;
	assign neg_s[0]  = neg;
	assign sat_s[0]  = {1'b0, rem_s[0]} >= {1'b0, den};

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [WORD_W-1:0] trial;
		logic              ge;

		// Bring down the next dividend bit and try a subtract.
		assign trial = {rem_s[i], bits_s[i][WORD_W-2]};
		assign ge    = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? (WORD_W-1)'(trial - {1'b0, den_s[i]})
				                  : trial[WORD_W-2:0];
				bits_s[i+1] <= {bits_s[i][WORD_W-3:0], 1'b0};
				q_s[i+1]    <= {q_s[i][WORD_W-3:0], ge};
				den_s[i+1]  <= den_s[i];
				neg_s[i+1]  <= neg_s[i];
				sat_s[i+1]  <= sat_s[i];
			end
		end
	end

	// Clamp on overflow and restore the sign.
	assign q_mag = sat_s[DIV_STAGES] ? {(WORD_W-1){1'b1}} : q_s[DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[DIV_STAGES] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		end
	end

endmodule

@@ sv/perspective_world_to_screen.sv @@
// Top level of the perspective world-to-screen projection pipeline.
// Depends on pwts_pkg, pwts_dot and pwts_div.
//
//  channel   | direction | payload
//  s_axis    | in        | tuser: operation; tdata: coef_index, coef_value, world_x/y/z
//  m_axis    | out       | tuser: visible; tdata: screen_x, screen_y
//  cfg       | in        | cfg_index, cfg_data (width, height, min depth)
//
// One item enters per cycle while the output is not stalled; a projected point passes 38
// register stages, the last of them the output register.
// Most of those stages are the divider's: 31 quotient stages plus a result register.
// Loads write the coefficient at acceptance and produce no result.
// Reset clears coefficients and all valid bits and sets the configuration to 1920 x 1080, min depth 66.
// A stalled output freezes the whole pipeline; s_axis_tready follows that stall.
module perspective_world_to_screen import pwts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // coef_index, coef_value, x, y, z
	input  logic                   s_axis_tuser,  // operation
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // screen_x, screen_y
	output logic                   m_axis_tuser,  // visible
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [DEPTH_W-1:0]     cfg_data
);

	localparam int SCL_W = WORD_W + DIM_W + 1;
	localparam int FIN_W = SCL_W + 2;

	logic               en;
	logic [DIM_W-1:0]   width_q, height_q;
	logic [DEPTH_W-1:0] depth_q;
	word_t              coef_q [0:COEF_SLOTS-1];
	logic [IDX_W-1:0]   in_idx;

	stage_ctl_t         ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s6, ctl_s7;
	stage_ctl_t         ctl_div [0:DIV_LAT];
	word_t              x_s1, y_s1, z_s1;
	word_t              cx_s3, cy_s3, cw_s3;
	logic [WORD_W-1:0]  mx_s4, my_s4;
	logic [WORD_W-2:0]  d_s4;
	logic               nx_s4, ny_s4;
	word_t              qx_s5, qy_s5;
	logic signed [SCL_W-1:0] px_s6, py_s6;
	logic signed [FIN_W-1:0] fx, fy;
	word_t              sx, sy;
	word_t              sx_s7, sy_s7;

	// The pipeline moves whenever the output register is free or being taken.
	assign en            = !ctl_s7.valid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign in_idx        = s_axis_tdata[IDX_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1920);
			height_q <= DIM_W'(1080);
			depth_q  <= DEPTH_W'(66);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_DEPTH:  depth_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Coefficient store, written by load requests as they are accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_SLOTS; i++) coef_q[i] <= '0;
		end else if (s_axis_tvalid && en && s_axis_tuser == OP_LOAD &&
		             in_idx < IDX_W'(COEF_SLOTS)) begin
			coef_q[in_idx] <= s_axis_tdata[IDX_W+WORD_W-1:IDX_W];
		end
	end

	// Control chain for the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: s_axis_tvalid && s_axis_tuser == OP_PROJECT, visible: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{valid: ctl_s3.valid,
			            visible: cw_s3 > $signed({{(WORD_W-DEPTH_W){1'b0}}, depth_q})};
		end
	end

	// Point register.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_axis_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];
			y_s1 <= s_axis_tdata[IDX_W+3*WORD_W-1:IDX_W+2*WORD_W];
			z_s1 <= s_axis_tdata[IDX_W+4*WORD_W-1:IDX_W+3*WORD_W];
		end
	end

	// Clip-space rows: products in stage 2, saturated sums in stage 3.
	pwts_dot u_row_x (.clk, .en, .c0(coef_q[0]), .c1(coef_q[1]), .c2(coef_q[2]),
		.c3(coef_q[3]), .x(x_s1), .y(y_s1), .z(z_s1), .dot_s3(cx_s3));
	pwts_dot u_row_y (.clk, .en, .c0(coef_q[4]), .c1(coef_q[5]), .c2(coef_q[6]),
		.c3(coef_q[7]), .x(x_s1), .y(y_s1), .z(z_s1), .dot_s3(cy_s3));
	pwts_dot u_row_w (.clk, .en, .c0(coef_q[8]), .c1(coef_q[9]), .c2(coef_q[10]),
		.c3(coef_q[11]), .x(x_s1), .y(y_s1), .z(z_s1), .dot_s3(cw_s3));

	// Magnitudes and signs for the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4 <= cx_s3[WORD_W-1] ? WORD_W'(-cx_s3) : WORD_W'(cx_s3);
			my_s4 <= cy_s3[WORD_W-1] ? WORD_W'(-cy_s3) : WORD_W'(cy_s3);
			nx_s4 <= cx_s3[WORD_W-1];
			ny_s4 <= cy_s3[WORD_W-1];
			d_s4  <= cw_s3[WORD_W-2:0];
		end
	end

	pwts_div u_div_x (.clk, .en, .mag(mx_s4), .den(d_s4), .neg(nx_s4), .quo(qx_s5));
	pwts_div u_div_y (.clk, .en, .mag(my_s4), .den(d_s4), .neg(ny_s4), .quo(qy_s5));

	// Control rides beside the dividers.
	assign ctl_div[0] = ctl_s4;
	for (genvar i = 0; i < DIV_LAT; i++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_div[i+1] <= '0;
			end else if (en) begin
				ctl_div[i+1] <= ctl_div[i];
			end
		end
	end

	// Quotient times viewport size.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s6 <= qx_s5 * $signed({1'b0, width_q});
			py_s6 <= qy_s5 * $signed({1'b0, height_q});
		end
	end

	// Half-scale with a rounding half (added for x, subtracted for the flipped y), centered on the viewport, saturated.
	always_comb begin
		fx = FIN_W'({width_q[DIM_W-1:1], {FRAC_BITS{1'b0}}})
		   + FIN_W'(px_s6 >>> 1) + FIN_W'(1 <<< (FRAC_BITS-1));
		fy = FIN_W'({height_q[DIM_W-1:1], {FRAC_BITS{1'b0}}})
		   - FIN_W'(py_s6 >>> 1) - FIN_W'(1 <<< (FRAC_BITS-1));
		if (fx > FIN_W'(32'sh7FFFFFFF))       sx = 32'sh7FFFFFFF;
		else if (fx < -FIN_W'(32'sh7FFFFFFF) - FIN_W'(1)) sx = 32'sh80000000;
		else                                  sx = fx[WORD_W-1:0];
		if (fy > FIN_W'(32'sh7FFFFFFF))       sy = 32'sh7FFFFFFF;
		else if (fy < -FIN_W'(32'sh7FFFFFFF) - FIN_W'(1)) sy = 32'sh80000000;
		else                                  sy = fy[WORD_W-1:0];
	end

	// Control for the back stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s6 <= ctl_div[DIV_LAT];
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s7 <= ctl_s6.visible ? sx : '0;
			sy_s7 <= ctl_s6.visible ? sy : '0;
		end
	end

	assign m_axis_tvalid = ctl_s7.valid;
	assign m_axis_tuser  = ctl_s7.visible;
	assign m_axis_tdata  = {sy_s7, sx_s7};

endmodule
